/* hdl/acmac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared types, constants and AES helper functions for the CMAC engine.
// ----------------------------------------------------------------------------
package acmac_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IDX_W   = 1;
    localparam logic [7:0]  CMAC_RB  = 8'h87;
    localparam logic [7:0]  CMAC_PAD = 8'h80;

    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    // Control from the top-level sequencer to the round unit.
    typedef struct packed {
        logic       start;   // load state with block ^ round key 0
        logic       step;    // run one round
        logic [3:0] round;   // round number 1..10 during step
    } t_rnd_ctrl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] y;
        unique case (x)
            8'h00: y=8'h63; 8'h01: y=8'h7c; 8'h02: y=8'h77; 8'h03: y=8'h7b;
            8'h04: y=8'hf2; 8'h05: y=8'h6b; 8'h06: y=8'h6f; 8'h07: y=8'hc5;
            8'h08: y=8'h30; 8'h09: y=8'h01; 8'h0a: y=8'h67; 8'h0b: y=8'h2b;
            8'h0c: y=8'hfe; 8'h0d: y=8'hd7; 8'h0e: y=8'hab; 8'h0f: y=8'h76;
            8'h10: y=8'hca; 8'h11: y=8'h82; 8'h12: y=8'hc9; 8'h13: y=8'h7d;
            8'h14: y=8'hfa; 8'h15: y=8'h59; 8'h16: y=8'h47; 8'h17: y=8'hf0;
            8'h18: y=8'had; 8'h19: y=8'hd4; 8'h1a: y=8'ha2; 8'h1b: y=8'haf;
            8'h1c: y=8'h9c; 8'h1d: y=8'ha4; 8'h1e: y=8'h72; 8'h1f: y=8'hc0;
            8'h20: y=8'hb7; 8'h21: y=8'hfd; 8'h22: y=8'h93; 8'h23: y=8'h26;
            8'h24: y=8'h36; 8'h25: y=8'h3f; 8'h26: y=8'hf7; 8'h27: y=8'hcc;
            8'h28: y=8'h34; 8'h29: y=8'ha5; 8'h2a: y=8'he5; 8'h2b: y=8'hf1;
            8'h2c: y=8'h71; 8'h2d: y=8'hd8; 8'h2e: y=8'h31; 8'h2f: y=8'h15;
            8'h30: y=8'h04; 8'h31: y=8'hc7; 8'h32: y=8'h23; 8'h33: y=8'hc3;
            8'h34: y=8'h18; 8'h35: y=8'h96; 8'h36: y=8'h05; 8'h37: y=8'h9a;
            8'h38: y=8'h07; 8'h39: y=8'h12; 8'h3a: y=8'h80; 8'h3b: y=8'he2;
            8'h3c: y=8'heb; 8'h3d: y=8'h27; 8'h3e: y=8'hb2; 8'h3f: y=8'h75;
            8'h40: y=8'h09; 8'h41: y=8'h83; 8'h42: y=8'h2c; 8'h43: y=8'h1a;
            8'h44: y=8'h1b; 8'h45: y=8'h6e; 8'h46: y=8'h5a; 8'h47: y=8'ha0;
            8'h48: y=8'h52; 8'h49: y=8'h3b; 8'h4a: y=8'hd6; 8'h4b: y=8'hb3;
            8'h4c: y=8'h29; 8'h4d: y=8'he3; 8'h4e: y=8'h2f; 8'h4f: y=8'h84;
            8'h50: y=8'h53; 8'h51: y=8'hd1; 8'h52: y=8'h00; 8'h53: y=8'hed;
            8'h54: y=8'h20; 8'h55: y=8'hfc; 8'h56: y=8'hb1; 8'h57: y=8'h5b;
            8'h58: y=8'h6a; 8'h59: y=8'hcb; 8'h5a: y=8'hbe; 8'h5b: y=8'h39;
            8'h5c: y=8'h4a; 8'h5d: y=8'h4c; 8'h5e: y=8'h58; 8'h5f: y=8'hcf;
            8'h60: y=8'hd0; 8'h61: y=8'hef; 8'h62: y=8'haa; 8'h63: y=8'hfb;
            8'h64: y=8'h43; 8'h65: y=8'h4d; 8'h66: y=8'h33; 8'h67: y=8'h85;
            8'h68: y=8'h45; 8'h69: y=8'hf9; 8'h6a: y=8'h02; 8'h6b: y=8'h7f;
            8'h6c: y=8'h50; 8'h6d: y=8'h3c; 8'h6e: y=8'h9f; 8'h6f: y=8'ha8;
            8'h70: y=8'h51; 8'h71: y=8'ha3; 8'h72: y=8'h40; 8'h73: y=8'h8f;
            8'h74: y=8'h92; 8'h75: y=8'h9d; 8'h76: y=8'h38; 8'h77: y=8'hf5;
            8'h78: y=8'hbc; 8'h79: y=8'hb6; 8'h7a: y=8'hda; 8'h7b: y=8'h21;
            8'h7c: y=8'h10; 8'h7d: y=8'hff; 8'h7e: y=8'hf3; 8'h7f: y=8'hd2;
            8'h80: y=8'hcd; 8'h81: y=8'h0c; 8'h82: y=8'h13; 8'h83: y=8'hec;
            8'h84: y=8'h5f; 8'h85: y=8'h97; 8'h86: y=8'h44; 8'h87: y=8'h17;
            8'h88: y=8'hc4; 8'h89: y=8'ha7; 8'h8a: y=8'h7e; 8'h8b: y=8'h3d;
            8'h8c: y=8'h64; 8'h8d: y=8'h5d; 8'h8e: y=8'h19; 8'h8f: y=8'h73;
            8'h90: y=8'h60; 8'h91: y=8'h81; 8'h92: y=8'h4f; 8'h93: y=8'hdc;
            8'h94: y=8'h22; 8'h95: y=8'h2a; 8'h96: y=8'h90; 8'h97: y=8'h88;
            8'h98: y=8'h46; 8'h99: y=8'hee; 8'h9a: y=8'hb8; 8'h9b: y=8'h14;
            8'h9c: y=8'hde; 8'h9d: y=8'h5e; 8'h9e: y=8'h0b; 8'h9f: y=8'hdb;
            8'ha0: y=8'he0; 8'ha1: y=8'h32; 8'ha2: y=8'h3a; 8'ha3: y=8'h0a;
            8'ha4: y=8'h49; 8'ha5: y=8'h06; 8'ha6: y=8'h24; 8'ha7: y=8'h5c;
            8'ha8: y=8'hc2; 8'ha9: y=8'hd3; 8'haa: y=8'hac; 8'hab: y=8'h62;
            8'hac: y=8'h91; 8'had: y=8'h95; 8'hae: y=8'he4; 8'haf: y=8'h79;
            8'hb0: y=8'he7; 8'hb1: y=8'hc8; 8'hb2: y=8'h37; 8'hb3: y=8'h6d;
            8'hb4: y=8'h8d; 8'hb5: y=8'hd5; 8'hb6: y=8'h4e; 8'hb7: y=8'ha9;
            8'hb8: y=8'h6c; 8'hb9: y=8'h56; 8'hba: y=8'hf4; 8'hbb: y=8'hea;
            8'hbc: y=8'h65; 8'hbd: y=8'h7a; 8'hbe: y=8'hae; 8'hbf: y=8'h08;
            8'hc0: y=8'hba; 8'hc1: y=8'h78; 8'hc2: y=8'h25; 8'hc3: y=8'h2e;
            8'hc4: y=8'h1c; 8'hc5: y=8'ha6; 8'hc6: y=8'hb4; 8'hc7: y=8'hc6;
            8'hc8: y=8'he8; 8'hc9: y=8'hdd; 8'hca: y=8'h74; 8'hcb: y=8'h1f;
            8'hcc: y=8'h4b; 8'hcd: y=8'hbd; 8'hce: y=8'h8b; 8'hcf: y=8'h8a;
            8'hd0: y=8'h70; 8'hd1: y=8'h3e; 8'hd2: y=8'hb5; 8'hd3: y=8'h66;
            8'hd4: y=8'h48; 8'hd5: y=8'h03; 8'hd6: y=8'hf6; 8'hd7: y=8'h0e;
            8'hd8: y=8'h61; 8'hd9: y=8'h35; 8'hda: y=8'h57; 8'hdb: y=8'hb9;
            8'hdc: y=8'h86; 8'hdd: y=8'hc1; 8'hde: y=8'h1d; 8'hdf: y=8'h9e;
            8'he0: y=8'he1; 8'he1: y=8'hf8; 8'he2: y=8'h98; 8'he3: y=8'h11;
            8'he4: y=8'h69; 8'he5: y=8'hd9; 8'he6: y=8'h8e; 8'he7: y=8'h94;
            8'he8: y=8'h9b; 8'he9: y=8'h1e; 8'hea: y=8'h87; 8'heb: y=8'he9;
            8'hec: y=8'hce; 8'hed: y=8'h55; 8'hee: y=8'h28; 8'hef: y=8'hdf;
            8'hf0: y=8'h8c; 8'hf1: y=8'ha1; 8'hf2: y=8'h89; 8'hf3: y=8'h0d;
            8'hf4: y=8'hbf; 8'hf5: y=8'he6; 8'hf6: y=8'h42; 8'hf7: y=8'h68;
            8'hf8: y=8'h41; 8'hf9: y=8'h99; 8'hfa: y=8'h2d; 8'hfb: y=8'h0f;
            8'hfc: y=8'hb0; 8'hfd: y=8'h54; 8'hfe: y=8'hbb; 8'hff: y=8'h16;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] y;
        unique case (r)
            4'd1: y = 8'h01;  4'd2: y = 8'h02;  4'd3: y = 8'h04;
            4'd4: y = 8'h08;  4'd5: y = 8'h10;  4'd6: y = 8'h20;
            4'd7: y = 8'h40;  4'd8: y = 8'h80;  4'd9: y = 8'h1b;
            4'd10: y = 8'h36;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    // CMAC doubling in GF(2^128).
    function automatic t_block dbl(input t_block x);
        t_block y;
        y = {x[BLOCK_W-2:0], 1'b0};
        if (x[BLOCK_W-1]) y[7:0] = y[7:0] ^ CMAC_RB;
        return y;
    endfunction

endpackage

/* hdl/acmac_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_round
// Shared AES-128 round unit: one round and one on-the-fly key step per cycle.
// ----------------------------------------------------------------------------
module acmac_round (
    input  logic                i_clk,
    input  acmac_pkg::t_rnd_ctrl i_ctrl,
    input  acmac_pkg::t_block   i_key,
    input  acmac_pkg::t_block   i_block,
    output acmac_pkg::t_block   o_state
);
    import acmac_pkg::*;

    t_block r_state, r_rkey;
    t_block w_sub, w_shf, w_mix, w_nkey, w_rnd;
    logic [31:0] w_tw;

    // byte b of the block sits at bits [127-8b -: 8]
    always_comb begin
        for (int b = 0; b < 16; b++) begin
            w_sub[127-8*b -: 8] = sbox(r_state[127-8*b -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_shf[127-8*(4*c+i) -: 8] = w_sub[127-8*(((c+i)%4)*4+i) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al, x01, x12, x23, x30;
            a0 = w_shf[127-32*c -: 8];
            a1 = w_shf[119-32*c -: 8];
            a2 = w_shf[111-32*c -: 8];
            a3 = w_shf[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            x01 = a0 ^ a1; x12 = a1 ^ a2; x23 = a2 ^ a3; x30 = a3 ^ a0;
            w_mix[127-32*c -: 8] = a0 ^ al ^ ({x01[6:0],1'b0} ^ (x01[7] ? 8'h1b : 8'h00));
            w_mix[119-32*c -: 8] = a1 ^ al ^ ({x12[6:0],1'b0} ^ (x12[7] ? 8'h1b : 8'h00));
            w_mix[111-32*c -: 8] = a2 ^ al ^ ({x23[6:0],1'b0} ^ (x23[7] ? 8'h1b : 8'h00));
            w_mix[103-32*c -: 8] = a3 ^ al ^ ({x30[6:0],1'b0} ^ (x30[7] ? 8'h1b : 8'h00));
        end
        // next round key
        w_tw = {sbox(r_rkey[23:16]), sbox(r_rkey[15:8]), sbox(r_rkey[7:0]),
                sbox(r_rkey[31:24])} ^ {rcon(i_ctrl.round), 24'h0};
        w_nkey[127:96] = r_rkey[127:96] ^ w_tw;
        w_nkey[95:64]  = r_rkey[95:64]  ^ w_nkey[127:96];
        w_nkey[63:32]  = r_rkey[63:32]  ^ w_nkey[95:64];
        w_nkey[31:0]   = r_rkey[31:0]   ^ w_nkey[63:32];
        w_rnd = ((i_ctrl.round == 4'd10) ? w_shf : w_mix) ^ w_nkey;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_state <= i_block ^ i_key;
            r_rkey  <= i_key;
        end else if (i_ctrl.step) begin
            r_state <= w_rnd;
            r_rkey  <= w_nkey;
        end
    end

    assign o_state = r_state;

endmodule

/* hdl/aes_cmac_tag_engine.sv */
`timescale 1ns / 1ps
// Sequence: an accepted request passes prepare, load, 10 rounds and finish;
//   a short non-last block is flagged at prepare instead. A block after a key
//   write first encrypts the zero block to derive the subkeys.
// Flow: one block at a time, set by the single shared AES round unit that
//   runs one round per cycle with an on-the-fly key schedule.
// Reset: synchronous active-low; clears key, chain value, subkey flag, FSM.
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine
// AES-128 CMAC tag engine over 128-bit message blocks.
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_mac_high,
    output logic [63:0] o_mac_low,
    output logic        o_length_error
);
    import acmac_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_KEYS, S_DONE, S_OUT}
        t_state;

    t_state      r_state;
    t_block      r_key, r_chain, r_k1, r_k2, r_blk, r_blk_hold;
    logic        r_kready, r_last, r_short, r_derive;
    logic [4:0]  r_cnt;
    logic [3:0]  r_round;
    t_rnd_ctrl   w_ctrl;
    t_block      w_aes, w_pad, w_msg, w_l;
    logic        r_ov, r_err;
    logic [127:0] r_mac;
    logic        w_out_free, w_emit;

    acmac_round u_round (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_key   (r_key),
        .i_block (r_blk),
        .o_state (w_aes)
    );

    always_comb begin
        w_ctrl.start = (r_state == S_LOAD);
        w_ctrl.step  = (r_state == S_ROUND);
        w_ctrl.round = r_round;
    end

    // Padding of a short last block: keep leading bytes, 0x80, then zeros.
    always_comb begin
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < r_cnt)       w_pad[127-8*b -: 8] = r_blk[127-8*b -: 8];
            else if (5'(b) == r_cnt) w_pad[127-8*b -: 8] = CMAC_PAD;
            else                     w_pad[127-8*b -: 8] = 8'h00;
        end
        if (!r_last)              w_msg = r_blk;
        else if (r_cnt == 5'd16)  w_msg = r_blk ^ r_k1;
        else                      w_msg = w_pad ^ r_k2;
        w_l = dbl(w_aes);
    end

    // Result register is free when empty or being taken this cycle; the
    // engine only waits on it at the step that produces a result.
    always_comb begin
        w_out_free = !r_ov || i_ready;
        w_emit     = w_out_free &&
                     (((r_state == S_DONE) && r_short) ||
                      ((r_state == S_KEYS) && !r_derive && r_last));
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_mac_high     = r_mac[127:64];
    assign o_mac_low      = r_mac[63:0];
    assign o_length_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_key    <= '0;
            r_chain  <= '0;
            r_kready <= 1'b0;
            r_ov     <= 1'b0;
            r_round  <= '0;
        end else begin
            r_ov <= w_emit || (r_ov && !i_ready);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEY_HIGH) r_key[127:64] <= i_cfg_data;
                else                           r_key[63:0]   <= i_cfg_data;
                r_kready <= 1'b0;
                r_chain  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cnt   <= (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
                        r_last  <= i_last;
                        r_short <= !i_last && (i_byte_count < 5'd16);
                        r_derive <= !r_kready;
                        if (!r_kready) begin
                            // encrypt the zero block first to get L
                            r_blk   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_blk   <= {i_data_high, i_data_low};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // message block prepared once subkeys are known
                    if (r_short) begin
                        if (w_out_free) begin
                            r_chain <= '0;
                            r_mac   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_blk   <= r_chain ^ w_msg;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_round <= 4'd1;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_round == 4'd10) r_state <= S_KEYS;
                    else r_round <= r_round + 4'd1;
                end
                S_KEYS: begin
                    if (r_derive) begin
                        r_k1     <= w_l;
                        r_k2     <= dbl(w_l);
                        r_kready <= 1'b1;
                        r_derive <= 1'b0;
                        r_blk    <= r_blk_hold;
                        r_state  <= S_DONE;
                    end else if (r_last) begin
                        if (w_out_free) begin
                            r_mac   <= w_aes;
                            r_err   <= 1'b0;
                            r_chain <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_chain <= w_aes;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Message block is held aside while the zero block is encrypted.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready) r_blk_hold <= {i_data_high, i_data_low};
    end

endmodule

/* tb/aes_cmac_tag_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine_test
// Self-checking bench for the CMAC tag engine: a behavioral AES-128 CMAC
// computes each expected tag or length flag as requests are accepted, and
// the monitor checks every result against it in order.
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine_test;
    import acmac_pkg::*;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        last;
    } t_request;

    typedef struct packed {
        logic [63:0] mac_high;
        logic [63:0] mac_low;
        logic        length_error;
    } t_tag;

    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_data_high;
    logic [63:0] i_data_low;
    logic [4:0]  i_byte_count;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_mac_high;
    logic [63:0] o_mac_low;
    logic        o_length_error;

    aes_cmac_tag_engine u_top (.*);

    // Behavioral CMAC state, mirrors the engine.
    logic [127:0] cmac_key;
    logic [127:0] cmac_chain;
    logic [127:0] cmac_k1;
    logic [127:0] cmac_k2;
    logic         cmac_subkeys_ok;
    logic [127:0] sched_keys [0:10];

    t_request request_q [$];
    t_tag     tag_q [$];
    int       fail_count;
    int       idle_cycles;
    int       send_gap;
    int       stall_gap;
    bit       stim_done;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_x2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] t;
        r = 8'h00;
        t = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ t;
            t = gf_x2(t);
        end
        return r;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] p;
        logic [7:0] a;
        logic [7:0] y;
        // multiplicative inverse by x^254, then the affine map
        inv = 8'h01;
        p = x;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) inv = gf_mul(inv, p);
            p = gf_mul(p, p);
        end
        if (x == 8'h00) inv = 8'h00;
        a = inv;
        y = a ^ {a[6:0], a[7]} ^ {a[5:0], a[7:6]} ^ {a[4:0], a[7:5]}
            ^ {a[3:0], a[7:4]} ^ 8'h63;
        return y;
    endfunction

    function automatic logic [7:0] rcon_byte(input int r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < r; i++) c = gf_x2(c);
        return c;
    endfunction

    task automatic expand_schedule();
        logic [31:0] w [0:43];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) w[i] = cmac_key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_byte(t[31:24]), sub_byte(t[23:16]),
                     sub_byte(t[15:8]), sub_byte(t[7:0])}
                    ^ {rcon_byte(i / 4), 24'h0};
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r <= 10; r++)
            sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] q;
        q = pt ^ sched_keys[0];
        for (int i = 0; i < 16; i++) s[i] = q[127-8*i -: 8];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) t[i] = sub_byte(s[i]);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[c*4+i] = t[((c+i)%4)*4+i];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[c*4]   = a0 ^ all ^ gf_x2(a0 ^ a1);
                    s[c*4+1] = a1 ^ all ^ gf_x2(a1 ^ a2);
                    s[c*4+2] = a2 ^ all ^ gf_x2(a2 ^ a3);
                    s[c*4+3] = a3 ^ all ^ gf_x2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ sched_keys[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) q[127-8*i -: 8] = s[i];
        return q;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
    endfunction

    // Absorb one accepted request; push the tag it produces, if any.
    task automatic cmac_absorb(input t_request req);
        logic [127:0] blk;
        logic [127:0] lval;
        int           n;
        t_tag         tag;
        n = (req.byte_count > 16) ? 16 : int'(req.byte_count);
        if (!cmac_subkeys_ok) begin
            expand_schedule();
            lval = aes_encrypt(128'h0);
            cmac_k1 = gf_double(lval);
            cmac_k2 = gf_double(cmac_k1);
            cmac_subkeys_ok = 1'b1;
        end
        blk = {req.data_high, req.data_low};
        if (!req.last) begin
            if (n < 16) begin
                cmac_chain = '0;
                tag = '{64'h0, 64'h0, 1'b1};
                tag_q.push_back(tag);
            end else begin
                cmac_chain = aes_encrypt(cmac_chain ^ blk);
            end
            return;
        end
        if (n == 16) begin
            blk = blk ^ cmac_k1;
        end else begin
            for (int i = n; i < 16; i++) blk[127-8*i -: 8] = 8'h00;
            blk[127-8*n -: 8] = CMAC_PAD;
            blk = blk ^ cmac_k2;
        end
        lval = aes_encrypt(cmac_chain ^ blk);
        tag = '{lval[127:64], lval[63:0], 1'b0};
        tag_q.push_back(tag);
        cmac_chain = '0;
    endtask

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents queued requests, holds each until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !o_ready) begin
            // hold
        end else begin
            if (i_valid) cmac_absorb({i_data_high, i_data_low, i_byte_count, i_last});
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                t_request req;
                req = request_q.pop_front();
                i_data_high  <= req.data_high;
                i_data_low   <= req.data_low;
                i_byte_count <= req.byte_count;
                i_last       <= req.last;
                i_valid      <= 1'b1;
                send_gap     <= rand_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expected tag.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (tag_q.size() == 0) begin
                    $error("unexpected result mac=%h_%h err=%b",
                           o_mac_high, o_mac_low, o_length_error);
                    fail_count++;
                end else begin
                    t_tag tag;
                    tag = tag_q.pop_front();
                    if (o_mac_high !== tag.mac_high) begin
                        $error("mac_high: expected %h, actual %h", tag.mac_high, o_mac_high);
                        fail_count++;
                    end
                    if (o_mac_low !== tag.mac_low) begin
                        $error("mac_low: expected %h, actual %h", tag.mac_low, o_mac_low);
                        fail_count++;
                    end
                    if (o_length_error !== tag.length_error) begin
                        $error("length_error: expected %b, actual %b",
                               tag.length_error, o_length_error);
                        fail_count++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (o_valid && i_ready) stall_gap <= rand_gap();
            end
        end
    end

    // Watchdog: any cycle without an accept counts toward the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || stim_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic [63:0] hi, input logic [63:0] lo,
                                 input logic [4:0] cnt, input logic lst);
        t_request req;
        req = '{hi, lo, cnt, lst};
        request_q.push_back(req);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Key write while idle; clears chain and subkeys in the model too.
    task automatic write_key_reg(input logic idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_KEY_HIGH) cmac_key[127:64] = value;
        else cmac_key[63:0] = value;
        cmac_subkeys_ok = 1'b0;
        cmac_chain = '0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for the driver and the result queue to drain, then a latency margin.
    task automatic drain_wait();
        wait (request_q.size() == 0 && !i_valid && tag_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic queue_message(input int blocks, input bit broken);
        for (int b = 0; b < blocks - 1; b++)
            queue_request(rand64(), rand64(), 5'd16, 1'b0);
        if (broken)
            queue_request(rand64(), rand64(), 5'($urandom_range(0, 15)), 1'b0);
        else
            queue_request(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b1);
    endtask

    initial begin
        int sent;
        int pick;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_KEY_HIGH;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data_high = '0;
        i_data_low = '0;
        i_byte_count = '0;
        i_last = 1'b0;
        fail_count = 0;
        stim_done = 1'b0;
        cmac_key = '0;
        cmac_chain = '0;
        cmac_k1 = '0;
        cmac_k2 = '0;
        cmac_subkeys_ok = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the standard test key first.
        write_key_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
        queue_request('0, '0, 5'd0, 1'b1);                        // empty message
        queue_request(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
        queue_request('1, '1, 5'd16, 1'b0);                       // two-block message
        queue_request('1, '1, 5'd15, 1'b1);
        queue_request('1, '1, 5'd31, 1'b1);                       // count saturates
        queue_request('1, '1, 5'd17, 1'b1);
        queue_request(rand64(), rand64(), 5'd16, 1'b0);          // abandoned by short block
        queue_request('1, '1, 5'd7, 1'b0);
        queue_request('0, '0, 5'd0, 1'b0);
        queue_request('1, '0, 5'd1, 1'b1);
        queue_request('0, '1, 5'd8, 1'b1);
        drain_wait();
        // Key extremes.
        write_key_reg(REG_KEY_HIGH, '1);
        write_key_reg(REG_KEY_LOW, '1);
        queue_request('1, '1, 5'd16, 1'b1);
        queue_request('0, '0, 5'd0, 1'b1);
        // Key write mid-message abandons it.
        queue_request(rand64(), rand64(), 5'd16, 1'b0);
        drain_wait();
        write_key_reg(REG_KEY_LOW, '0);
        queue_request('0, '0, 5'd16, 1'b1);
        drain_wait();
        write_key_reg(REG_KEY_HIGH, '0);
        queue_request('0, '0, 5'd16, 1'b1);
        drain_wait();

        // Random messages, with occasional key changes.
        sent = 0;
        while (sent < 1100) begin
            if ($urandom_range(0, 19) == 0) begin
                drain_wait();
                write_key_reg(REG_KEY_HIGH, rand64());
                if ($urandom_range(0, 1)) write_key_reg(REG_KEY_LOW, rand64());
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                int n;
                n = $urandom_range(1, 4);
                queue_message(n, 1'b0);
                sent += n;
            end else if (pick < 75) begin
                int m;
                m = $urandom_range(1, 3);
                queue_message(m, 1'b1);
                sent += m;
            end else begin
                queue_request(rand64(), rand64(), 5'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                sent += 1;
            end
            wait (request_q.size() < 8);
        end
        wait (request_q.size() == 0 && !i_valid && tag_q.size() == 0);
        stim_done = 1'b1;
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && tag_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
